### sv/fbfla_pkg.sv
// Shared types and constants for the fixed block free list allocator.
`default_nettype none
package fbfla_pkg;

    localparam int MAX_BLOCKS  = 64;
    localparam int BLOCK_BYTES = 1024;

    localparam int BLK_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W = 11;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    typedef logic [BLK_W-1:0] t_blk;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_FREE   = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    // Per-cycle operation applied to every cell of the stack chain.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PUSH = 2'd1,
        CELL_POP  = 2'd2,
        CELL_LOAD = 2'd3
    } t_cell_op;

endpackage : fbfla_pkg
`default_nettype wire

### sv/fixed_block_free_list_allocator_unit.sv
// Top level of the fixed block free list allocator.
// An accepted transaction's result is registered in the output register.
// Throughput: one transaction per cycle unless the output stalls; the stack shift and
// count update finish in the same cycle, so the next one sees the new state at once.
// Reset (synchronous, active low): list empty, all blocks unused, block_count = 64,
// output register empty. Stack cells are not reset; only filled entries are read.
`default_nettype none
module fixed_block_free_list_allocator_unit
    import fbfla_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [CNT_W-1:0]    i_cfg_data,
    // request channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [SIZE_W-1:0]   i_request_size,
    input  wire logic [BLK_W-1:0]    i_block_index,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_granted,
    output logic [BLK_W-1:0]         o_given_block,
    output logic [STAT_W-1:0]        o_status
);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_cnt                  r_block_count;
    t_cnt                  r_free_count;
    t_cnt                  n_free_count;
    // One bit per block: set while the block holds a nonzero recorded size.
    // Only "nonzero" is ever observed, so the size value itself is not kept.
    logic [MAX_BLOCKS-1:0] r_used;

    logic                  r_out_valid;
    logic                  r_granted;
    t_blk                  r_given_block;
    t_status               r_status;

    // Transaction taken when valid and not stalled.
    logic in_acc;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------
    // Stack chain: cell 0 is the top of the free list.
    // Push shifts every entry one cell down, pop one cell up.
    // ---------------------------------------------------------------
    t_cell_op cell_op;
    t_blk     cell_data [MAX_BLOCKS];

    for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
        t_blk push_src;
        t_blk pop_src;

        if (k == 0) begin : g_top
            assign push_src = i_block_index;
        end else begin : g_mid
            assign push_src = cell_data[k-1];
        end

        if (k == MAX_BLOCKS - 1) begin : g_bot
            assign pop_src = cell_data[k];
        end else begin : g_up
            assign pop_src = cell_data[k+1];
        end

        // Init loads block k into cell k: block 0 ends up on top.
        fbfla_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (cell_op),
            .i_push_data (push_src),
            .i_pop_data  (pop_src),
            .i_load_data (BLK_W'(k)),
            .o_data      (cell_data[k])
        );
    end

    // ---------------------------------------------------------------
    // Command decode
    // ---------------------------------------------------------------
    t_cmd    cmd;
    t_cnt    init_n;
    logic    res_granted;
    t_blk    res_block;
    t_status res_status;
    logic    used_set;      // record allocation into block res_block
    logic    used_clr;      // clear the freed block
    logic    used_clr_all;  // init wipes every record

    assign cmd    = t_cmd'(i_command);
    // block_count above the pool size saturates
    assign init_n = (r_block_count > t_cnt'(MAX_BLOCKS)) ? t_cnt'(MAX_BLOCKS)
                                                         : r_block_count;

    always_comb begin
        res_granted  = 1'b0;
        res_block    = '0;
        res_status   = ST_OK;
        n_free_count = r_free_count;
        cell_op      = CELL_HOLD;
        used_set     = 1'b0;
        used_clr     = 1'b0;
        used_clr_all = 1'b0;

        if (in_acc) begin
            case (cmd)
                CMD_ALLOC: begin
                    if (i_request_size > SIZE_W'(BLOCK_BYTES)) begin
                        res_status = ST_TOO_LARGE;
                    end else if (r_free_count == '0) begin
                        res_status = ST_NO_FREE;
                    end else begin
                        res_granted  = 1'b1;
                        res_block    = cell_data[0];
                        n_free_count = r_free_count - t_cnt'(1);
                        cell_op      = CELL_POP;
                        used_set     = 1'b1;
                    end
                end
                CMD_FREE: begin
                    // unused block, double free or zero-size block: ignored
                    if (!r_used[i_block_index] ||
                        r_free_count >= t_cnt'(MAX_BLOCKS)) begin
                        res_status = ST_IGNORED;
                    end else begin
                        res_granted  = 1'b1;
                        n_free_count = r_free_count + t_cnt'(1);
                        cell_op      = CELL_PUSH;
                        used_clr     = 1'b1;
                    end
                end
                CMD_INIT: begin
                    n_free_count = init_n;
                    cell_op      = CELL_LOAD;
                    used_clr_all = 1'b1;
                end
                default: begin
                    // unused command: all-zero result, no state change
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= t_cnt'(MAX_BLOCKS);
            r_free_count  <= '0;
            r_used        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_block_count <= i_cfg_data;
            end
            r_free_count <= n_free_count;
            if (used_clr_all) begin
                r_used <= '0;
            end else if (used_set) begin
                // a zero-size allocation leaves the block unfreeable
                r_used[res_block] <= (i_request_size != '0);
            end else if (used_clr) begin
                r_used[i_block_index] <= 1'b0;
            end
            if (!o_in_stall) begin
                r_out_valid <= in_acc;
            end
        end
    end

    // Result payload: loaded with each accepted transaction, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_granted     <= res_granted;
            r_given_block <= res_block;
            r_status      <= res_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_granted;
    assign o_given_block = r_given_block;
    assign o_status      = r_status;

endmodule : fixed_block_free_list_allocator_unit
`default_nettype wire

### sv/fbfla_cell.sv
// One cell of the free list shift stack: holds a single block index.
`default_nettype none
module fbfla_cell
    import fbfla_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_cell_op i_op,
    input  wire t_blk     i_push_data,  // from the cell nearer the top
    input  wire t_blk     i_pop_data,   // from the cell further down
    input  wire t_blk     i_load_data,  // this cell's own position
    output t_blk          o_data
);

    t_blk r_data;
    t_blk n_data;

    always_comb begin
        case (i_op)
            CELL_PUSH: n_data = i_push_data;
            CELL_POP:  n_data = i_pop_data;
            CELL_LOAD: n_data = i_load_data;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule : fbfla_cell
`default_nettype wire

### sv/fbfla_chk.sv
// Port-level checker for the fixed block free list allocator, bound to the top level.
`default_nettype none
module fbfla_chk
    import fbfla_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                o_in_stall,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_stall,
    input  wire logic                o_granted,
    input  wire logic [BLK_W-1:0]    o_given_block,
    input  wire logic [STAT_W-1:0]   o_status
);

    // A granted result always carries an ok status.
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted) |-> (o_status == ST_OK))
        else $error("granted result with non-ok status");

    // A refused request never names a block.
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_given_block == '0))
        else $error("refused result names a block");

    // Input side only stalls while a result is held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_granted) && $stable(o_given_block)
             && $stable(o_status)))
        else $error("stalled result changed");

endmodule : fbfla_chk

bind fixed_block_free_list_allocator_unit fbfla_chk u_fbfla_chk (.*);
`default_nettype wire
